[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, codes and types of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int CELL_W = $clog2(CELLS);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CH_W   = 8;
  localparam int ATTR_W = 8;
  localparam int FUNC_W = 2;

  localparam int QDEPTH = 4;
  localparam int Q_AW   = $clog2(QDEPTH);

  localparam logic [CH_W-1:0] NEWLINE_CH = 8'd10;
  localparam logic [CH_W-1:0] ERROR_CH   = 8'd69;
  localparam logic [CH_W-1:0] SPACE_CH   = 8'd32;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST   = 8'd244;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT   = 2'd0,
    FN_READ  = 2'd1,
    FN_CLEAR = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic {
    REG_DEFAULT_ATTR = 1'b0,
    REG_ERROR_ATTR   = 1'b1
  } reg_idx_t;

  // Classified request as it travels from the front end to the executor.
  typedef struct packed {
    func_t              func;
    logic [CH_W-1:0]    ch;
    logic [ATTR_W-1:0]  attr;
    logic               use_cursor;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               in_range;
    logic               newline;
    logic [CELL_W-1:0]  lin;
  } tcw_op_t;

  typedef struct packed {
    logic init_busy;
  } tcw_stat_t;

endpackage

`default_nettype wire

[sv/tcw_req_if.sv]
// ----------------------------------------------------------------------------
// tcw_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CH_W-1:0]   ch;
  logic [ATTR_W-1:0] attr;
  logic              use_cursor;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, func, ch, attr, use_cursor, col, row, input ready);
  modport sink   (input valid, func, ch, attr, use_cursor, col, row, output ready);
endinterface

`default_nettype wire

[sv/tcw_rsp_if.sv]
// ----------------------------------------------------------------------------
// tcw_rsp_if
// Response channel: valid/ready handshake with the response fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_rsp_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              status;
  logic              scrolled;
  logic [CH_W-1:0]   read_char;
  logic [ATTR_W-1:0] read_attr;

  modport source (output valid, cursor_col, cursor_row, status, scrolled,
                  read_char, read_attr, input ready);
  modport sink   (input valid, cursor_col, cursor_row, status, scrolled,
                  read_char, read_attr, output ready);
endinterface

`default_nettype wire

[sv/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests, checks the explicit position and forms its cell index.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
  tcw_req_if.sink              req,
  input  tcw_pkg::tcw_stat_t   stat,
  input  logic                 q_full,
  output logic                 q_push,
  output tcw_pkg::tcw_op_t     q_item
);
  import tcw_pkg::*;

  logic col_ok;
  logic row_ok;

  assign col_ok = ({1'b0, req.col} < (COL_W+1)'(COLS));
  assign row_ok = ({1'b0, req.row} < (ROW_W+1)'(ROWS));

  assign req.ready = !q_full && !stat.init_busy;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    q_item.func       = func_t'(req.func);
    q_item.ch         = req.ch;
    q_item.attr       = req.attr;
    q_item.use_cursor = req.use_cursor;
    q_item.col        = req.col;
    q_item.row        = req.row;
    q_item.in_range   = req.use_cursor || (col_ok && row_ok);
    q_item.newline    = (req.ch == NEWLINE_CH);
    q_item.lin        = CELL_W'(CELL_W'(req.row) * CELL_W'(COLS)) + CELL_W'(req.col);
  end

endmodule

`default_nettype wire

[sv/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO of classified requests between front end and executor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcw_pkg::tcw_op_t   push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output tcw_pkg::tcw_op_t   head
);
  import tcw_pkg::*;

  tcw_op_t         slots [QDEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW+1)'(QDEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Executes requests on the screen store: writes, reads, init, scroll and clear
// sweeps, cursor update, response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tcw_pkg::ATTR_W-1:0]  default_attr,
  input  logic [tcw_pkg::ATTR_W-1:0]  error_attr,
  input  logic                        q_valid,
  input  tcw_pkg::tcw_op_t            q_item,
  output logic                        q_pop,
  output tcw_pkg::tcw_stat_t          stat,
  tcw_rsp_if.source                   rsp
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_CLEAR
  } state_t;

  localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] LAST_ROW0  = CELL_W'(CELLS - COLS);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  logic [CH_W+ATTR_W-1:0] mem [CELLS];
  logic [CH_W+ATTR_W-1:0] rdata;

  state_t              state;
  logic [CELL_W-1:0]   cnt;
  logic [COL_W-1:0]    cur_col;
  logic [ROW_W-1:0]    cur_row;
  logic [CELL_W-1:0]   cur_lin;

  logic                we;
  logic [CELL_W-1:0]   waddr;
  logic [CH_W+ATTR_W-1:0] wdata;
  logic [CELL_W-1:0]   raddr;

  logic                take;
  logic [COL_W-1:0]    sel_col;
  logic [ROW_W-1:0]    sel_row;
  logic [CELL_W-1:0]   sel_lin;
  logic [ATTR_W-1:0]   put_attr;
  logic                at_row_end;
  logic                wrap;
  logic [COL_W-1:0]    new_col;
  logic [ROW_W-1:0]    new_row;

  assign stat.init_busy = (state == ST_INIT);
  assign take  = (state == ST_IDLE) && q_valid && (!rsp.valid || rsp.ready);
  assign q_pop = take;

  assign cur_lin  = CELL_W'(CELL_W'(cur_row) * CELL_W'(COLS)) + CELL_W'(cur_col);
  assign sel_col  = q_item.use_cursor ? cur_col : q_item.col;
  assign sel_row  = q_item.use_cursor ? cur_row : q_item.row;
  assign sel_lin  = q_item.use_cursor ? cur_lin : q_item.lin;
  assign put_attr = (q_item.attr == '0) ? default_attr : q_item.attr;

  // Newline always leaves the row; a character leaves it only at the last column.
  assign at_row_end = q_item.newline || (sel_col == LAST_COL);
  assign wrap       = at_row_end && (sel_row == LAST_ROW);
  assign new_col    = at_row_end ? '0 : sel_col + 1'b1;
  assign new_row    = (at_row_end && !wrap) ? sel_row + 1'b1 : sel_row;

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = '0;
    raddr = sel_lin;
    unique case (state)
      ST_INIT: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        if (take && q_item.func == FN_PUT) begin
          if (!q_item.in_range) begin
            we    = 1'b1;
            waddr = LAST_CELL;
            wdata = {error_attr, ERROR_CH};
          end else if (!q_item.newline) begin
            we    = 1'b1;
            waddr = sel_lin;
            wdata = {put_attr, q_item.ch};
          end
        end
      end
      ST_READ: begin
      end
      ST_COPY: begin
        // read one row ahead, write the previous read back in the next cycle
        raddr = (cnt < LAST_ROW0) ? cnt + CELL_W'(COLS) : '0;
        if (cnt != '0) begin
          we    = 1'b1;
          waddr = cnt - 1'b1;
          wdata = rdata;
        end
      end
      ST_FILL: begin
        we = 1'b1;
      end
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = {default_attr, SPACE_CH};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_CELL) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            rsp.cursor_col <= cur_col;
            rsp.cursor_row <= cur_row;
            rsp.status     <= 1'b0;
            rsp.scrolled   <= 1'b0;
            rsp.read_char  <= '0;
            rsp.read_attr  <= '0;
            unique case (q_item.func)
              FN_PUT: begin
                if (!q_item.in_range) begin
                  rsp.status <= 1'b1;
                  rsp.valid  <= 1'b1;
                end else begin
                  cur_col        <= new_col;
                  cur_row        <= new_row;
                  rsp.cursor_col <= new_col;
                  rsp.cursor_row <= new_row;
                  if (wrap) begin
                    cnt   <= '0;
                    state <= ST_COPY;
                  end else begin
                    rsp.valid <= 1'b1;
                  end
                end
              end
              FN_READ: begin
                if (!q_item.in_range) begin
                  rsp.status <= 1'b1;
                  rsp.valid  <= 1'b1;
                end else begin
                  state <= ST_READ;
                end
              end
              FN_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                cnt     <= '0;
                state   <= ST_CLEAR;
              end
              FN_NOP: begin
                rsp.valid <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          rsp.read_char <= rdata[CH_W-1:0];
          rsp.read_attr <= rdata[CH_W+ATTR_W-1:CH_W];
          rsp.valid     <= 1'b1;
          state         <= ST_IDLE;
        end
        ST_COPY: begin
          if (cnt == LAST_ROW0) begin
            state <= ST_FILL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_CELL) begin
            cnt          <= '0;
            rsp.scrolled <= 1'b1;
            rsp.valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_CELL) begin
            cnt            <= '0;
            rsp.cursor_col <= '0;
            rsp.cursor_row <= '0;
            rsp.valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/text_console_char_writer.sv]
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console engine: character/attribute screen store with cursor,
// newline, scroll, clear and cell read.
//
//   channel  dir  handshake          contents
//   req      in   valid/ready        func, ch, attr, use_cursor, col, row
//   rsp      out  valid/ready        cursor_col/row, status, scrolled, read cell
//   apb      in   psel/penable/pwrite  default_attr @0x0, error_attr @0x4
//
// Put without scroll, out-of-range request and nop finish from the idle state;
// read goes through a read state. Scroll copies the rows up through the store's
// one write port and one read port, then zero-fills the last row. Clear blanks every cell.
// After reset the store is zeroed; req.ready stays low meanwhile.
// Requests queue in a 4-entry FIFO while the executor or rsp is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer (
  input  logic                         clk,
  input  logic                         rst,
  tcw_req_if.sink                      req,
  tcw_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
  output logic [tcw_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] default_attr;
  logic [ATTR_W-1:0] error_attr;
  reg_idx_t          reg_idx;

  tcw_stat_t stat;
  logic      q_full;
  logic      q_push;
  tcw_op_t   q_in;
  logic      q_pop;
  logic      q_valid;
  tcw_op_t   q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
      error_attr   <= ERROR_ATTR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DEFAULT_ATTR: default_attr <= pwdata[ATTR_W-1:0];
        REG_ERROR_ATTR:   error_attr   <= pwdata[ATTR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEFAULT_ATTR: prdata = PDATA_W'(default_attr);
      REG_ERROR_ATTR:   prdata = PDATA_W'(error_attr);
    endcase
  end

  tcw_front u_front (
    .req    (req),
    .stat   (stat),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .default_attr (default_attr),
    .error_attr   (error_attr),
    .q_valid      (q_valid),
    .q_item       (q_head),
    .q_pop        (q_pop),
    .stat         (stat),
    .rsp          (rsp)
  );

endmodule

`default_nettype wire

[sim/text_console_char_writer_tb.sv]
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking testbench for the text console character writer. Requests go
// in over the request channel with random gaps. Each accepted request runs
// through a behavioral mirror of the screen store, the cursor and the two
// attribute registers, and the expected report is queued. The response
// channel stalls at random and once for a long stretch. Each report is
// checked field by field against the oldest queued one. Directed tests cover
// the edge positions, newline, scroll, error mark, clear and nop. Random
// traffic then runs under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer_tb;
  import tcw_pkg::*;

  typedef struct packed {
    func_t             func;
    logic [CH_W-1:0]   ch;
    logic [ATTR_W-1:0] attr;
    logic              use_cursor;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } console_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              status;
    logic              scrolled;
    logic [CH_W-1:0]   read_char;
    logic [ATTR_W-1:0] read_attr;
  } console_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();

  text_console_char_writer i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the block state
  logic [15:0]       screen_mirror [CELLS];
  int                cursor_mirror;
  logic [ATTR_W-1:0] dflt_attr_mirror;
  logic [ATTR_W-1:0] err_attr_mirror;

  console_rsp_t console_reports_q[$];
  int           error_count = 0;
  bit           gaps_on = 1'b1;
  int           rsp_hold_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic console_req_t make_request(func_t f, int ch, int attr, bit use_cursor,
                                                int col, int row);
    console_req_t r;
    r.func       = f;
    r.ch         = ch[CH_W-1:0];
    r.attr       = attr[ATTR_W-1:0];
    r.use_cursor = use_cursor;
    r.col        = col[COL_W-1:0];
    r.row        = row[ROW_W-1:0];
    return r;
  endfunction

  // Applies one request to the mirror and returns the report it should give
  function automatic console_rsp_t apply_console_request(console_req_t r);
    console_rsp_t res;
    int pos;
    int i;
    bit in_range;
    logic [ATTR_W-1:0] at;
    res      = '0;
    in_range = r.use_cursor || (r.col < COLS && r.row < ROWS);
    pos      = r.use_cursor ? cursor_mirror : r.row * COLS + r.col;
    at       = (r.attr == '0) ? dflt_attr_mirror : r.attr;
    case (r.func)
      FN_PUT: begin
        if (!in_range) begin
          screen_mirror[CELLS-1] = {err_attr_mirror, ERROR_CH};
          res.status = 1'b1;
        end else begin
          if (r.ch == NEWLINE_CH) begin
            pos = (pos / COLS + 1) * COLS;
          end else begin
            screen_mirror[pos] = {at, r.ch};
            pos++;
          end
          if (pos >= CELLS) begin
            for (i = 0; i + COLS < CELLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
            for (i = CELLS - COLS; i < CELLS; i++) screen_mirror[i] = '0;
            pos -= COLS;
            res.scrolled = 1'b1;
          end
          cursor_mirror = pos;
        end
      end
      FN_READ: begin
        if (!in_range) res.status = 1'b1;
        else {res.read_attr, res.read_char} = screen_mirror[pos];
      end
      FN_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_mirror[i] = {dflt_attr_mirror, SPACE_CH};
        cursor_mirror = 0;
      end
      default: ;
    endcase
    res.cursor_col = COL_W'(cursor_mirror % COLS);
    res.cursor_row = ROW_W'(cursor_mirror / COLS);
    return res;
  endfunction

  // Holds valid high between back-to-back requests
  task automatic issue_request(console_req_t r);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= r.func;
    req_ch.ch         <= r.ch;
    req_ch.attr       <= r.attr;
    req_ch.use_cursor <= r.use_cursor;
    req_ch.col        <= r.col;
    req_ch.row        <= r.row;
    do @(posedge clk); while (!req_ch.ready);
    console_reports_q.push_back(apply_console_request(r));
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (console_reports_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_console_reg(reg_idx_t idx, logic [ATTR_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(PDATA_W-ATTR_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DEFAULT_ATTR) dflt_attr_mirror = value;
    else err_attr_mirror = value;
    @(posedge clk);
  endtask

  function automatic console_req_t random_request();
    console_req_t r;
    int sel;
    r.func       = func_t'($urandom_range(0, 3));
    r.ch         = CH_W'($urandom_range(0, 255));
    r.attr       = ATTR_W'($urandom_range(0, 255));
    r.use_cursor = 1'($urandom_range(0, 1));
    r.col        = COL_W'($urandom_range(0, 127));
    r.row        = ROW_W'($urandom_range(0, 31));
    sel          = $urandom_range(0, 99);
    if (sel < 77) r.func = FN_PUT;
    else if (sel < 96) r.func = FN_READ;
    else if (sel < 98) r.func = FN_NOP;
    else r.func = FN_CLEAR;
    if (sel < 55 || (sel >= 77 && sel < 83)) begin
      r.use_cursor = 1'b1;
    end else if (sel < 72 || (sel >= 83 && sel < 92)) begin
      r.use_cursor = 1'b0;
      r.col        = COL_W'($urandom_range(0, COLS - 1));
      r.row        = ROW_W'(($urandom_range(0, 2) == 0) ? ROWS - 1
                                                        : $urandom_range(0, ROWS - 1));
    end else if (sel < 96) begin
      r.use_cursor = 1'b0;
    end
    if ($urandom_range(0, 9) == 0) r.ch = NEWLINE_CH;
    if ($urandom_range(0, 6) == 0) r.attr = '0;
    return r;
  endfunction

  // Response ready: random stalls plus an occasional long hold-off
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else begin
        n = gap_len();
      end
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_reports
    console_rsp_t got;
    console_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.cursor_col, rsp_ch.cursor_row, rsp_ch.status, rsp_ch.scrolled,
             rsp_ch.read_char, rsp_ch.read_attr};
      if (console_reports_q.size() == 0) begin
        $error("unexpected report: %p", got);
        error_count++;
      end else begin
        want = console_reports_q.pop_front();
        if (got.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
          error_count++;
        end
        if (got.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
          error_count++;
        end
        if (got.read_char !== want.read_char) begin
          $error("read_char: expected %0d, got %0d", want.read_char, got.read_char);
          error_count++;
        end
        if (got.read_attr !== want.read_attr) begin
          $error("read_attr: expected %0d, got %0d", want.read_attr, got.read_attr);
          error_count++;
        end
      end
    end
  end

  task automatic test_after_reset();
    issue_request(make_request(FN_READ, 0, 0, 1'b0, 0, 0));
    issue_request(make_request(FN_READ, 0, 0, 1'b1, 127, 31));
    issue_request(make_request(FN_NOP, 255, 255, 1'b1, 127, 31));
  endtask

  task automatic test_put_and_read();
    issue_request(make_request(FN_PUT, 65, 0, 1'b1, 0, 0));
    issue_request(make_request(FN_PUT, 255, 255, 1'b0, COLS - 1, 0));
    issue_request(make_request(FN_READ, 0, 0, 1'b0, COLS - 1, 0));
    issue_request(make_request(FN_READ, 0, 0, 1'b0, COLS, 0));
    issue_request(make_request(FN_READ, 0, 0, 1'b0, 127, 31));
    // out of range put leaves an error mark in the last cell
    issue_request(make_request(FN_PUT, 66, 7, 1'b0, 0, ROWS));
    issue_request(make_request(FN_READ, 0, 0, 1'b0, COLS - 1, ROWS - 1));
  endtask

  task automatic test_newline_and_scroll();
    issue_request(make_request(FN_PUT, 0, 1, 1'b0, COLS - 1, ROWS - 1));
    issue_request(make_request(FN_PUT, NEWLINE_CH, 0, 1'b1, 0, 0));
    issue_request(make_request(FN_PUT, NEWLINE_CH, 3, 1'b0, 5, 10));
    issue_request(make_request(FN_READ, 0, 0, 1'b1, 0, 0));
  endtask

  task automatic test_clear_and_nop();
    issue_request(make_request(FN_CLEAR, 255, 255, 1'b0, 127, 31));
    issue_request(make_request(FN_READ, 0, 0, 1'b0, 40, 12));
    issue_request(make_request(FN_NOP, 0, 0, 1'b0, 0, 0));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_console_reg(REG_DEFAULT_ATTR, 8'hff);
    write_console_reg(REG_ERROR_ATTR, 8'h00);
    issue_request(make_request(FN_PUT, 90, 0, 1'b1, 0, 0));
    issue_request(make_request(FN_PUT, 90, 0, 1'b0, COLS, ROWS - 1));
    issue_request(make_request(FN_READ, 0, 0, 1'b0, COLS - 1, ROWS - 1));
    wait_idle();
  endtask

  task automatic test_response_backpressure();
    int i;
    gaps_on = 1'b0;
    rsp_hold_cycles = 300;
    for (i = 0; i < 24; i++) issue_request(random_request());
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(int n_items);
    int p;
    int i;
    for (p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_console_reg(REG_DEFAULT_ATTR, 8'h00);
          write_console_reg(REG_ERROR_ATTR, 8'hff);
        end
        1: begin
          write_console_reg(REG_DEFAULT_ATTR, ATTR_W'($urandom_range(1, 254)));
          write_console_reg(REG_ERROR_ATTR, ATTR_W'($urandom_range(1, 254)));
        end
        default: begin
          write_console_reg(REG_DEFAULT_ATTR, DEFAULT_ATTR_RST);
          write_console_reg(REG_ERROR_ATTR, ERROR_ATTR_RST);
        end
      endcase
      gaps_on = (p != 1);
      for (i = 0; i < n_items / 4; i++) issue_request(random_request());
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    int i;
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= '0;
    req_ch.ch         <= '0;
    req_ch.attr       <= '0;
    req_ch.use_cursor <= 1'b0;
    req_ch.col        <= '0;
    req_ch.row        <= '0;
    for (i = 0; i < CELLS; i++) screen_mirror[i] = '0;
    cursor_mirror    = 0;
    dflt_attr_mirror = DEFAULT_ATTR_RST;
    err_attr_mirror  = ERROR_ATTR_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_put_and_read();
    test_newline_and_scroll();
    test_clear_and_nop();
    test_register_extremes();
    test_response_backpressure();
    test_random_traffic(880);

    wait_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/tcw_pkg.sv
sv/tcw_req_if.sv
sv/tcw_rsp_if.sv
sv/tcw_front.sv
sv/tcw_queue.sv
sv/tcw_back.sv
sv/text_console_char_writer.sv
sim/text_console_char_writer_tb.sv
